// ===== sv/zbpsr_pkg.sv =====
// shared constants, types and the splat window test for the point splat rasteriser
`default_nettype none
package zbpsr_pkg;

  localparam int TILE_SIZE    = 256;
  localparam int SPLAT_RADIUS = 2;
  localparam int PIXELS       = TILE_SIZE * TILE_SIZE;
  localparam int ADDR_W       = $clog2(PIXELS);
  localparam int TILE_W       = $clog2(TILE_SIZE);
  localparam int COORD_W      = TILE_W + 2;
  localparam int WIN          = 2 * SPLAT_RADIUS;
  localparam int WIN_W        = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int DEPTH_W      = 32;
  localparam int RGB_W        = 24;

  // -99999.0 in signed 24.8
  localparam logic signed [DEPTH_W-1:0] EMPTY_DEPTH_RESET = -32'sd25599744;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLOT  = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef struct packed {
    logic             cov;
    logic [RGB_W-1:0] rgb;
  } pix_t;

  // window position ix, iy maps to offsets ix-R, iy-R; true inside the disc
  function automatic logic in_disc(logic [WIN_W-1:0] ix, logic [WIN_W-1:0] iy);
    int dx;
    int dy;
    dx = int'(ix) - SPLAT_RADIUS;
    dy = int'(iy) - SPLAT_RADIUS;
    return ((dx * dx + dy * dy) <= (SPLAT_RADIUS * SPLAT_RADIUS));
  endfunction

endpackage
`default_nettype wire

// ===== sv/zbuffered_point_splat_raster_unit.sv =====
// top level: z-buffered point splat rasteriser over a square rgba tile
// The tile lives in two synchronous memories, each with one write and one
// read port, one holding colour plus a coverage bit and one holding depth,
// each TILE_SIZE x TILE_SIZE deep. After reset and after every clear item the
// block sweeps both memories, one pixel a cycle, and in_tready stays low until
// the last pixel is written; configuration writes are taken throughout. A plot
// item inside the tile reads the stored depth and compares it; if it wins, its
// depth is written and it steps through each of the (2R)x(2R) window positions,
// writing colour at those inside the disc and the tile. A plot outside the
// tile or one that loses the depth test writes nothing. A read item goes
// through the colour memory read port into the output register, and waits
// while a previous result is still pending. Only read items produce a result.
`default_nettype none
module zbuffered_point_splat_raster_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,     // empty_depth
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // column[11:0], row[23:12], depth[55:24], red_in[63:56], green_in[71:64],
  // blue_in[79:72], pixel_index[95:80]
  input  wire logic [95:0] in_tdata,
  input  wire logic [1:0]  in_tuser,     // opcode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
  output logic [31:0]      out_tdata
);

  localparam int AW  = zbpsr_pkg::ADDR_W;
  localparam int TW  = zbpsr_pkg::TILE_W;
  localparam int CW  = zbpsr_pkg::COORD_W;
  localparam int WW  = zbpsr_pkg::WIN_W;
  localparam int DW  = zbpsr_pkg::DEPTH_W;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_CMP,
    S_STAMP,
    S_RDATA
  } state_t;

  // input fields
  logic [11:0]          f_column;
  logic [11:0]          f_row;
  logic signed [DW-1:0] f_depth;
  logic [23:0]          f_rgb;
  logic [15:0]          f_pixel_index;

  assign f_column      = in_tdata[11:0];
  assign f_row         = in_tdata[23:12];
  assign f_depth       = in_tdata[55:24];
  assign f_rgb         = {in_tdata[63:56], in_tdata[71:64], in_tdata[79:72]};
  assign f_pixel_index = in_tdata[95:80];

  // registers
  state_t               state_r, state_nxt;
  logic [TW-1:0]        col_r, col_nxt;
  logic [TW-1:0]        row_r, row_nxt;
  logic signed [DW-1:0] depth_r, depth_nxt;
  logic [23:0]          rgb_r, rgb_nxt;
  logic [WW-1:0]        wx_r, wx_nxt;
  logic [WW-1:0]        wy_r, wy_nxt;
  logic [AW-1:0]        sweep_cnt_r, sweep_cnt_nxt;
  logic signed [DW-1:0] sweep_depth_r, sweep_depth_nxt;
  logic signed [DW-1:0] empty_depth_r;
  logic                 rd_hit_r, rd_hit_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [31:0]          out_tdata_r, out_tdata_nxt;

  // memories
  zbpsr_pkg::pix_t      cmem [zbpsr_pkg::PIXELS];
  logic [DW-1:0]        dmem [zbpsr_pkg::PIXELS];
  zbpsr_pkg::pix_t      cmem_q_r;
  logic signed [DW-1:0] dmem_q_r;

  logic                 cmem_we, cmem_re;
  logic [AW-1:0]        cmem_waddr, cmem_raddr;
  zbpsr_pkg::pix_t      cmem_wdata;
  logic                 dmem_we, dmem_re;
  logic [AW-1:0]        dmem_waddr, dmem_raddr;
  logic [DW-1:0]        dmem_wdata;

  // decode and address arithmetic
  logic          accept;
  logic          col_in, row_in;
  logic [AW-1:0] centre_in;
  logic [AW-1:0] centre_r_addr;
  logic [CW-1:0] xp, yp;
  logic          x_ok, y_ok;
  logic [TW-1:0] xa, ya;
  logic [AW-1:0] stamp_addr;
  logic          win_x_last, win_y_last;
  logic          sweep_last;

  assign accept    = in_tvalid && in_tready;
  assign col_in    = !f_column[11] && (f_column < 12'(zbpsr_pkg::TILE_SIZE));
  assign row_in    = !f_row[11] && (f_row < 12'(zbpsr_pkg::TILE_SIZE));
  assign centre_in = AW'(f_row[TW-1:0]) * AW'(zbpsr_pkg::TILE_SIZE)
                     + AW'(f_column[TW-1:0]);
  assign centre_r_addr = AW'(row_r) * AW'(zbpsr_pkg::TILE_SIZE) + AW'(col_r);

  // window coordinates biased by +R so they stay unsigned
  assign xp   = CW'(col_r) + CW'(wx_r);
  assign yp   = CW'(row_r) + CW'(wy_r);
  assign x_ok = (xp >= CW'(zbpsr_pkg::SPLAT_RADIUS))
             && (xp < CW'(zbpsr_pkg::TILE_SIZE + zbpsr_pkg::SPLAT_RADIUS));
  assign y_ok = (yp >= CW'(zbpsr_pkg::SPLAT_RADIUS))
             && (yp < CW'(zbpsr_pkg::TILE_SIZE + zbpsr_pkg::SPLAT_RADIUS));
  assign xa   = TW'(xp - CW'(zbpsr_pkg::SPLAT_RADIUS));
  assign ya   = TW'(yp - CW'(zbpsr_pkg::SPLAT_RADIUS));
  assign stamp_addr = AW'(ya) * AW'(zbpsr_pkg::TILE_SIZE) + AW'(xa);

  assign win_x_last = (wx_r == WW'(zbpsr_pkg::WIN - 1));
  assign win_y_last = (wy_r == WW'(zbpsr_pkg::WIN - 1));
  assign sweep_last = (sweep_cnt_r == AW'(zbpsr_pkg::PIXELS - 1));

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt       = state_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    depth_nxt       = depth_r;
    rgb_nxt         = rgb_r;
    wx_nxt          = wx_r;
    wy_nxt          = wy_r;
    sweep_cnt_nxt   = sweep_cnt_r;
    sweep_depth_nxt = sweep_depth_r;
    rd_hit_nxt      = rd_hit_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_tdata_nxt   = out_tdata_r;

    cmem_we    = 1'b0;
    cmem_waddr = stamp_addr;
    cmem_wdata = '{cov: 1'b1, rgb: rgb_r};
    cmem_re    = 1'b0;
    cmem_raddr = AW'(f_pixel_index);
    dmem_we    = 1'b0;
    dmem_waddr = centre_r_addr;
    dmem_wdata = depth_r;
    dmem_re    = 1'b0;
    dmem_raddr = centre_in;

    case (state_r)
      S_SWEEP: begin
        cmem_we       = 1'b1;
        cmem_waddr    = sweep_cnt_r;
        cmem_wdata    = '0;
        dmem_we       = 1'b1;
        dmem_waddr    = sweep_cnt_r;
        dmem_wdata    = sweep_depth_r;
        sweep_cnt_nxt = sweep_cnt_r + AW'(1);
        if (sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_tuser)
            zbpsr_pkg::OP_CLEAR: begin
              sweep_cnt_nxt   = '0;
              sweep_depth_nxt = empty_depth_r;
              state_nxt       = S_SWEEP;
            end
            zbpsr_pkg::OP_PLOT: begin
              col_nxt   = f_column[TW-1:0];
              row_nxt   = f_row[TW-1:0];
              depth_nxt = f_depth;
              rgb_nxt   = f_rgb;
              if (col_in && row_in) begin
                dmem_re   = 1'b1;
                state_nxt = S_CMP;
              end
            end
            zbpsr_pkg::OP_READ: begin
              rd_hit_nxt = (32'(f_pixel_index) < 32'(zbpsr_pkg::PIXELS));
              cmem_re    = 1'b1;
              state_nxt  = S_RDATA;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CMP: begin
        if (dmem_q_r < depth_r) begin
          dmem_we   = 1'b1;
          wx_nxt    = '0;
          wy_nxt    = '0;
          state_nxt = S_STAMP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_STAMP: begin
        cmem_we = zbpsr_pkg::in_disc(wx_r, wy_r) && x_ok && y_ok;
        if (win_x_last) begin
          wx_nxt = '0;
          wy_nxt = wy_r + WW'(1);
          if (win_y_last) begin
            state_nxt = S_IDLE;
          end
        end else begin
          wx_nxt = wx_r + WW'(1);
        end
      end
      S_RDATA: begin
        // read data register holds while the previous result is still pending
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = rd_hit_r ? {{8{cmem_q_r.cov}}, cmem_q_r.rgb[7:0],
                                       cmem_q_r.rgb[15:8], cmem_q_r.rgb[23:16]}
                                    : 32'd0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_SWEEP;
      sweep_cnt_r   <= '0;
      sweep_depth_r <= zbpsr_pkg::EMPTY_DEPTH_RESET;
      empty_depth_r <= zbpsr_pkg::EMPTY_DEPTH_RESET;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sweep_cnt_r   <= sweep_cnt_nxt;
      sweep_depth_r <= sweep_depth_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        empty_depth_r <= cfg_data;
      end
    end
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    depth_r     <= depth_nxt;
    rgb_r       <= rgb_nxt;
    wx_r        <= wx_nxt;
    wy_r        <= wy_nxt;
    rd_hit_r    <= rd_hit_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmem_we) begin
      cmem[cmem_waddr] <= cmem_wdata;
    end
    if (cmem_re) begin
      cmem_q_r <= cmem[cmem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dmem_we) begin
      dmem[dmem_waddr] <= dmem_wdata;
    end
    if (dmem_re) begin
      dmem_q_r <= dmem[dmem_raddr];
    end
  end

  // a result only ever comes out of the read data state
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_RDATA))
    else $error("result raised outside a read");

  // a depth write from a plot always raises the stored depth
  a_depth_rises: assert property (@(posedge clk) disable iff (!rst_n)
    (dmem_we && state_r != S_SWEEP) |-> ($signed(dmem_wdata) > dmem_q_r))
    else $error("depth written without winning the compare");

  // clipped stamp writes stay inside the tile
  a_stamp_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
    (cmem_we && state_r == S_STAMP) |-> (32'(cmem_waddr) < 32'(zbpsr_pkg::PIXELS)))
    else $error("stamp write beyond the tile");

  // a sweep runs to its last pixel without a break
  a_sweep_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && !sweep_last) |=> (state_r == S_SWEEP))
    else $error("sweep left early");

endmodule
`default_nettype wire
